// File: hw/rtl/min_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the min priority queue
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MIN_PRIORITY_QUEUE_ASSERT_SVH
`define MIN_PRIORITY_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// The consequent must hold in the cycle after the antecedent.
`define MPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// File: hw/rtl/mpq_pkg.sv
// ----------------------------------------------------------------------------
// Min priority queue package
// Field widths, action and status codes, and the cell control type.
// ----------------------------------------------------------------------------
`default_nettype none

package mpq_pkg;

    localparam int KEY_W            = 32;
    localparam int ACTION_W         = 2;
    localparam int STATUS_W         = 2;
    localparam int DEFAULT_CAPACITY = 64;

    // Input tdata: action, key_in; padded to whole bytes.
    localparam int IN_DATA_W = ((ACTION_W + KEY_W + 7) / 8) * 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    // Shift command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic rem;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/mpq_cell.sv
// ----------------------------------------------------------------------------
// Min priority queue cell
// One slot of the sorted chain: keeps its key on insert, takes the new key,
// or takes the key of its left neighbor; on removal it takes the right one.
// ----------------------------------------------------------------------------
`default_nettype none

module mpq_cell (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire mpq_pkg::cell_ctrl_t            ctrl,
    input  wire logic signed [mpq_pkg::KEY_W-1:0] new_key,
    input  wire logic signed [mpq_pkg::KEY_W-1:0] left_key,
    input  wire                                 left_valid,
    input  wire                                 left_ahead,
    input  wire logic signed [mpq_pkg::KEY_W-1:0] right_key,
    input  wire                                 right_valid,
    output logic signed [mpq_pkg::KEY_W-1:0]    key,
    output logic                                valid,
    output logic                                ahead
);
    import mpq_pkg::*;

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic                    valid_reg;
    logic                    valid_next;

    // The new key belongs at or ahead of this slot. An empty slot counts as
    // holding an infinitely large key, so the flags along the chain are monotone;
    // with a slot free, exactly one cell sees its own flag set and its left clear.
    assign ahead = !valid_reg || (new_key < key_reg);

    always_comb begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctrl.ins && ahead) begin
            if (left_ahead) begin
                key_next   = left_key;
                valid_next = left_valid;
            end else begin
                key_next   = new_key;
                valid_next = 1'b1;
            end
        end else if (ctrl.rem) begin
            key_next   = right_key;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        key_reg <= key_next;
    end

    assign key   = key_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

// File: hw/rtl/min_priority_queue.sv
// ----------------------------------------------------------------------------
// Min priority queue
// Output: each result is captured in the output register when its transfer is accepted.
// Throughput: one item per cycle when not stalled; at most one chain shift per action.
// The chain keeps keys sorted, so the minimum always sits in the first cell.
// Reset: aresetn, synchronous, clears the count, all cell valid bits and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module min_priority_queue #(
    parameter int CAPACITY = mpq_pkg::DEFAULT_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int OUT_W    = ((mpq_pkg::STATUS_W + mpq_pkg::KEY_W + CNT_W + 7) / 8) * 8
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    // [1:0] action, [33:2] key_in, rest zero
    input  wire [mpq_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // [1:0] status, [33:2] key_out, then entry_count, rest zero
    output logic [OUT_W-1:0]                m_axis_tdata
);
    import mpq_pkg::*;

    localparam int KEY_LSB = STATUS_W;
    localparam int CNT_LSB = STATUS_W + KEY_W;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [OUT_W-1:0]  out_data_reg;
    logic [OUT_W-1:0]  out_data_next;

    logic              accept;
    action_t           action;
    logic signed [KEY_W-1:0] key_in;
    logic              is_full;
    logic              is_empty;
    cell_ctrl_t        ctrl;
    status_t           status;
    logic signed [KEY_W-1:0] key_result;

    logic signed [KEY_W-1:0] cell_key    [CAPACITY];
    logic                    cell_valid  [CAPACITY];
    logic                    cell_ahead  [CAPACITY];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign action        = action_t'(s_axis_tdata[ACTION_W-1:0]);
    assign key_in        = s_axis_tdata[ACTION_W +: KEY_W];
    assign is_full       = (count_reg == CNT_W'(CAPACITY));
    assign is_empty      = (count_reg == '0);

    always_comb begin
        ctrl       = '0;
        status     = ST_OK;
        key_result = '0;
        count_next = count_reg;
        unique case (action)
            ACT_INSERT: begin
                if (is_full) begin
                    status = ST_FULL;
                end else begin
                    ctrl.ins   = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_QUERY: begin
                if (is_empty) begin
                    status = ST_EMPTY;
                end else begin
                    key_result = cell_key[0];
                end
            end
            ACT_REMOVE: begin
                if (is_empty) begin
                    status = ST_EMPTY;
                end else begin
                    key_result = cell_key[0];
                    ctrl.rem   = accept;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        out_data_next                          = '0;
        out_data_next[STATUS_W-1:0]            = status;
        out_data_next[KEY_LSB +: KEY_W]        = key_result;
        out_data_next[CNT_LSB +: CNT_W]        = count_next;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
        if (accept) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic signed [KEY_W-1:0] left_key;
            logic                    left_valid;
            logic                    left_ahead;
            logic signed [KEY_W-1:0] right_key;
            logic                    right_valid;

            if (gi == 0) begin : g_head
                assign left_key    = '0;
                assign left_valid  = 1'b0;
                assign left_ahead  = 1'b0;
            end else begin : g_body
                assign left_key    = cell_key[gi-1];
                assign left_valid  = cell_valid[gi-1];
                assign left_ahead  = cell_ahead[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign right_key   = '0;
                assign right_valid = 1'b0;
            end else begin : g_link
                assign right_key   = cell_key[gi+1];
                assign right_valid = cell_valid[gi+1];
            end

            mpq_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .new_key     (key_in),
                .left_key    (left_key),
                .left_valid  (left_valid),
                .left_ahead  (left_ahead),
                .right_key   (right_key),
                .right_valid (right_valid),
                .key         (cell_key[gi]),
                .valid       (cell_valid[gi]),
                .ahead       (cell_ahead[gi])
            );
        end
    endgenerate

endmodule

`default_nettype wire

// File: hw/rtl/mpq_checker.sv
// ----------------------------------------------------------------------------
// Min priority queue port checker
// Watches the result stream for consistent status, key and count fields.
// ----------------------------------------------------------------------------
`default_nettype none

`include "min_priority_queue_assert.svh"

module mpq_port_checker #(
    parameter int CAPACITY = mpq_pkg::DEFAULT_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int OUT_W    = ((mpq_pkg::STATUS_W + mpq_pkg::KEY_W + CNT_W + 7) / 8) * 8
) (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          s_axis_tready,
    input wire                          m_axis_tvalid,
    input wire                          m_axis_tready,
    input wire [OUT_W-1:0]              m_axis_tdata
);
    import mpq_pkg::*;

    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key_out;
    logic [CNT_W-1:0]    count;

    assign status  = m_axis_tdata[STATUS_W-1:0];
    assign key_out = m_axis_tdata[STATUS_W +: KEY_W];
    assign count   = m_axis_tdata[STATUS_W + KEY_W +: CNT_W];

    `MPQ_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))

    // An empty output register must never hold off the input side.
    `MPQ_ASSERT_NOW(a_ready_when_idle, aclk, aresetn, !m_axis_tvalid, s_axis_tready)

    `MPQ_ASSERT_NOW(a_full_count, aclk, aresetn, m_axis_tvalid && (status == ST_FULL),
        (count == CNT_W'(CAPACITY)) && (key_out == '0))

    `MPQ_ASSERT_NOW(a_empty_count, aclk, aresetn, m_axis_tvalid && (status == ST_EMPTY),
        (count == '0) && (key_out == '0))

endmodule

bind min_priority_queue mpq_port_checker #(
    .CAPACITY (CAPACITY)
) u_mpq_port_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: tb/mpq_checker.sv
// ----------------------------------------------------------------------------
// Min priority queue checker
// Watches both stream channels of the queue. For every accepted command it
// works out the status, key and entry count that the queue must return, and
// compares each returned transfer with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module mpq_checker
    import mpq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int OUT_W    = ((STATUS_W + KEY_W + CNT_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [OUT_W-1:0]     m_axis_tdata,
    output int                   fail_count,
    output int                   pending_count
);

    typedef struct packed {
        status_t          status;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } reply_t;

    // Keys currently held by the queue, in arrival order.
    logic signed [KEY_W-1:0] held_keys[$];
    reply_t                  replies_due[$];
    int                      mismatches = 0;

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    function automatic reply_t apply_command(input action_t act, input logic [KEY_W-1:0] key);
        reply_t reply;
        int     low_idx;
        reply = '{status: ST_OK, key: '0, count: '0};
        case (act)
            ACT_INSERT: begin
                if (held_keys.size() >= CAPACITY) begin
                    reply.status = ST_FULL;
                end else begin
                    held_keys.push_back(key);
                end
            end
            ACT_QUERY, ACT_REMOVE: begin
                if (held_keys.size() == 0) begin
                    reply.status = ST_EMPTY;
                end else begin
                    low_idx = 0;
                    foreach (held_keys[i]) begin
                        if (held_keys[i] < held_keys[low_idx]) low_idx = i;
                    end
                    reply.key = held_keys[low_idx];
                    if (act == ACT_REMOVE) held_keys.delete(low_idx);
                end
            end
            default: ;
        endcase
        reply.count = CNT_W'(held_keys.size());
        return reply;
    endfunction

    always @(posedge aclk) begin : watch
        reply_t           want;
        status_t          got_status;
        logic [KEY_W-1:0] got_key;
        logic [CNT_W-1:0] got_count;
        if (aresetn) begin
            // A result is registered before it leaves, so it always leaves after its
            // command has been accepted; the output side is therefore handled first.
            if (m_axis_tvalid && m_axis_tready) begin
                got_status = status_t'(m_axis_tdata[STATUS_W-1:0]);
                got_key    = m_axis_tdata[STATUS_W +: KEY_W];
                got_count  = m_axis_tdata[STATUS_W + KEY_W +: CNT_W];
                if (replies_due.size() == 0) begin
                    $error("result transfer with nothing outstanding: tdata %h", m_axis_tdata);
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    if (got_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got_status);
                        mismatches++;
                    end
                    if (got_key !== want.key) begin
                        $error("key_out: expected %0d, actual %0d",
                               $signed(want.key), $signed(got_key));
                        mismatches++;
                    end
                    if (got_count !== want.count) begin
                        $error("entry_count: expected %0d, actual %0d", want.count, got_count);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                replies_due.push_back(apply_command(action_t'(s_axis_tdata[ACTION_W-1:0]),
                                                    s_axis_tdata[ACTION_W +: KEY_W]));
            end
        end
        fail_count    <= mismatches;
        pending_count <= replies_due.size();
    end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Min priority queue testbench
// Drives directed corner commands and then segments of random commands that
// fill the queue to capacity, drain it past empty and mix both, with random
// stalls on both channels. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

    import mpq_pkg::*;

    localparam int CAPACITY     = DEFAULT_CAPACITY;
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int OUT_W        = ((STATUS_W + KEY_W + CNT_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 1700;
    localparam int QUIET_ITEMS  = 150;
    localparam int HOLD_AT      = 400;
    localparam int LONG_HOLD    = 250;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum logic [1:0] {
        SEG_FILL,
        SEG_MIX,
        SEG_DRAIN
    } segment_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;
    int                   fail_count;
    int                   pending_count;
    int                   random_sent = 0;
    bit                   quiet       = 1'b0;
    bit                   hold_done   = 1'b0;
    int                   cycle_count = 0;

    min_priority_queue #(.CAPACITY(CAPACITY)) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mpq_checker #(.CAPACITY(CAPACITY)) checker_inst (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** min_priority_queue: FAILED **");
            $finish;
        end
    end

    task automatic send_command(input action_t act, input logic [KEY_W-1:0] key);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W - ACTION_W - KEY_W){1'b0}}, key, act};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic sender_gap(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Stop offering until every outstanding result has been taken.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    function automatic logic [KEY_W-1:0] random_key();
        int pick;
        pick = $urandom_range(0, 7);
        case (pick)
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            // A narrow range around zero produces plenty of equal keys.
            1, 2: return KEY_W'($urandom_range(0, 16) - 8);
            default: return $urandom;
        endcase
    endfunction

    function automatic action_t random_action(input segment_t seg);
        int roll;
        roll = $urandom_range(0, 99);
        case (seg)
            SEG_FILL: begin
                if (roll < 85) return ACT_INSERT;
                if (roll < 92) return ACT_QUERY;
                if (roll < 97) return ACT_REMOVE;
            end
            SEG_MIX: begin
                if (roll < 45) return ACT_INSERT;
                if (roll < 65) return ACT_QUERY;
                if (roll < 95) return ACT_REMOVE;
            end
            default: begin
                if (roll < 20) return ACT_INSERT;
                if (roll < 40) return ACT_QUERY;
                if (roll < 97) return ACT_REMOVE;
            end
        endcase
        return ACT_NOP;
    endfunction

    // Receiver: random stall bursts, one long hold-off while the sender keeps
    // offering, and a steady ready at the end of the run.
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            if (quiet) begin
                m_axis_tready <= 1'b1;
                @(posedge aclk);
            end else if (!hold_done && random_sent >= HOLD_AT) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_done = 1'b1;
            end else if ($urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) repeat ($urandom_range(20, 60)) @(posedge aclk);
                else repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
        end
    end

    initial begin
        segment_t seg;
        int       seg_idx;
        int       seg_len;
        int       gap_pct;
        int       sent;
        bit       steady;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty queue, the unused action code, both key extremes and equal keys.
        send_command(ACT_QUERY,  32'h1234_5678);
        send_command(ACT_REMOVE, 32'hFFFF_FFFF);
        send_command(ACT_NOP,    32'hFFFF_FFFF);
        send_command(ACT_INSERT, 32'h7FFF_FFFF);
        send_command(ACT_QUERY,  32'h0000_0000);
        sender_gap(3);
        send_command(ACT_INSERT, 32'h8000_0000);
        send_command(ACT_QUERY,  32'h0000_0000);
        send_command(ACT_INSERT, 32'h0000_0000);
        send_command(ACT_INSERT, 32'hFFFF_FFFF);
        send_command(ACT_INSERT, 32'h0000_0001);
        send_command(ACT_INSERT, 32'h8000_0000);
        send_command(ACT_NOP,    32'h0000_0000);
        send_command(ACT_QUERY,  32'hAAAA_5555);
        sender_gap(2);
        for (int i = 0; i < 7; i++) send_command(ACT_REMOVE, 32'h5555_AAAA);
        send_command(ACT_QUERY,  32'h0000_0000);
        wait_for_results();

        sent    = 0;
        seg_idx = 0;
        while (sent < RANDOM_ITEMS) begin
            case (seg_idx % 4)
                0:       seg = SEG_FILL;
                2:       seg = SEG_DRAIN;
                default: seg = SEG_MIX;
            endcase
            seg_len = $urandom_range(60, 160);
            gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
            for (int i = 0; i < seg_len && sent < RANDOM_ITEMS; i++) begin
                send_command(random_action(seg), random_key());
                sent++;
                random_sent <= sent;
                quiet       <= (sent >= RANDOM_ITEMS - QUIET_ITEMS);
                // Keep offering while the receiver holds off, so the input stalls.
                steady = (sent >= RANDOM_ITEMS - QUIET_ITEMS) ||
                         (sent >= HOLD_AT && !hold_done);
                if (!steady && $urandom_range(1, 100) <= gap_pct)
                    sender_gap($urandom_range(1, 5));
            end
            if (sent < RANDOM_ITEMS - QUIET_ITEMS &&
                (seg_idx == 1 || $urandom_range(0, 2) == 0))
                wait_for_results();
            seg_idx++;
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("** min_priority_queue: PASSED **");
        end else begin
            $display("** min_priority_queue: FAILED **");
        end
        $finish;
    end

endmodule
